// ===== hw/rtl/crx_pkg.sv =====
// shared constants, codes and types for the checksummed frame receiver
`default_nettype none

package crx_pkg;

  // payload buffer depth default
  localparam int unsigned BufDepth = 1024;

  // request codes
  localparam logic [1:0] ReqByte = 2'd0;
  localparam logic [1:0] ReqIdle = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;

  // status codes
  localparam logic [2:0] StNone      = 3'd0;
  localparam logic [2:0] StAccept    = 3'd1;
  localparam logic [2:0] StLenDrop   = 3'd2;
  localparam logic [2:0] StSumBad    = 3'd3;
  localparam logic [2:0] StTailBad   = 3'd4;
  localparam logic [2:0] StIdleReset = 3'd5;

  // register reset values
  localparam logic [7:0]  HeaderReset = 8'hAA;
  localparam logic [7:0]  TailReset   = 8'h55;
  localparam logic [15:0] IdleReset   = 16'd1000;

  typedef struct packed {
    logic [7:0]  header_value;
    logic [7:0]  tail_value;
    logic [15:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_cmd;
    logic [10:0] frame_len;
    logic [7:0]  read_data;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crx_if.sv =====
// valid/ready channel interfaces for the request and result streams
`default_nettype none

interface crx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic [9:0] read_index;

  modport source (output valid, output req_type, output data_byte, output read_index,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input read_index,
                output ready);
endinterface

interface crx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_cmd;
  logic [10:0] frame_len;
  logic [7:0]  read_data;

  modport source (output valid, output status, output frame_cmd, output frame_len,
                  output read_data, input ready);
  modport sink (input valid, input status, input frame_cmd, input frame_len,
                input read_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crx_cfg.sv =====
// apb configuration registers: header byte, tail byte, idle limit
`default_nettype none

module crx_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output crx_pkg::cfg_t     cfg_o
);

  localparam logic [1:0] RegHeader = 2'd0;
  localparam logic [1:0] RegTail   = 2'd1;
  localparam logic [1:0] RegIdle   = 2'd2;

  crx_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegHeader: cfg_d.header_value = pwdata[7:0];
        RegTail:   cfg_d.tail_value   = pwdata[7:0];
        RegIdle:   cfg_d.idle_limit   = pwdata[15:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value <= crx_pkg::HeaderReset;
      cfg_q.tail_value   <= crx_pkg::TailReset;
      cfg_q.idle_limit   <= crx_pkg::IdleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegHeader: prdata = {24'd0, cfg_q.header_value};
      RegTail:   prdata = {24'd0, cfg_q.tail_value};
      RegIdle:   prdata = {16'd0, cfg_q.idle_limit};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/crx_ctrl.sv =====
// deframing state, checksum and payload buffer with one result stage
`default_nettype none

module crx_ctrl #(
  parameter int unsigned BUF_DEPTH = crx_pkg::BufDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire crx_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [9:0]    read_index_i,
  output logic               res_valid_o,
  output crx_pkg::res_t      res_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned PW = $clog2(BUF_DEPTH + 1);

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhCmd    = 3'd1;
  localparam logic [2:0] PhLenLo  = 3'd2;
  localparam logic [2:0] PhLenHi  = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;
  localparam logic [2:0] PhSum    = 3'd5;
  localparam logic [2:0] PhTail   = 3'd6;

  logic [2:0]    phase_q, phase_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    len_lo_q, len_lo_d;
  logic [15:0]   len_q, len_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    sum_q, sum_d;
  logic [15:0]   idle_q, idle_d, idle_inc;
  logic [15:0]   len_rx;

  logic          stg_valid_q;
  logic [2:0]    stg_status_q, status_d;
  logic [7:0]    stg_cmd_q;
  logic [10:0]   stg_len_q;
  logic          stg_rd_q, rd_d;

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    mem_rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  assign len_rx   = {data_byte_i, len_lo_q};
  assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign wr_addr  = AW'(pos_q);
  assign rd_addr  = AW'(read_index_i);

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    idle_d   = idle_q;
    status_d = crx_pkg::StNone;
    rd_d     = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (accept_i) begin
      case (req_type_i)
        crx_pkg::ReqByte: begin
          idle_d = 16'd0;
          case (phase_q)
            PhCmd: begin
              cmd_d   = data_byte_i;
              sum_d   = data_byte_i;
              phase_d = PhLenLo;
            end
            PhLenLo: begin
              len_lo_d = data_byte_i;
              sum_d    = sum_q + data_byte_i;
              phase_d  = PhLenHi;
            end
            PhLenHi: begin
              len_d = len_rx;
              sum_d = sum_q + data_byte_i;
              pos_d = '0;
              if (32'(len_rx) > 32'(BUF_DEPTH)) begin
                status_d = crx_pkg::StLenDrop;
                phase_d  = PhHeader;
              end else begin
                phase_d = (len_rx != 16'd0) ? PhData : PhSum;
              end
            end
            PhData: begin
              if (32'(pos_q) < 32'(BUF_DEPTH)) begin
                mem_we = 1'b1;
                pos_d  = pos_q + 1'b1;
              end
              sum_d = sum_q + data_byte_i;
              if (32'(pos_d) >= 32'(len_q)) begin
                phase_d = PhSum;
              end
            end
            PhSum: begin
              if (data_byte_i == sum_q) begin
                phase_d = PhTail;
              end else begin
                status_d = crx_pkg::StSumBad;
                phase_d  = PhHeader;
              end
            end
            PhTail: begin
              status_d = (data_byte_i == cfg_i.tail_value) ? crx_pkg::StAccept
                                                           : crx_pkg::StTailBad;
              phase_d  = PhHeader;
            end
            default: begin
              phase_d = (data_byte_i == cfg_i.header_value) ? PhCmd : PhHeader;
            end
          endcase
        end
        crx_pkg::ReqIdle: begin
          // idle ticks only count once a header has been seen
          if (phase_q == PhHeader || phase_q > PhTail) begin
            phase_d = PhHeader;
          end else if (idle_inc > cfg_i.idle_limit) begin
            phase_d  = PhHeader;
            idle_d   = 16'd0;
            status_d = crx_pkg::StIdleReset;
          end else begin
            idle_d = idle_inc;
          end
        end
        crx_pkg::ReqRead: begin
          rd_d   = 32'(read_index_i) < 32'(BUF_DEPTH);
          mem_re = rd_d;
        end
        default: begin
          rd_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      cmd_q       <= 8'd0;
      len_lo_q    <= 8'd0;
      len_q       <= 16'd0;
      pos_q       <= '0;
      sum_q       <= 8'd0;
      idle_q      <= 16'd0;
      stg_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      len_lo_q    <= len_lo_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      idle_q      <= idle_d;
      stg_valid_q <= accept_i;
    end
  end

  // result stage lines up with the registered buffer read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stg_status_q <= status_d;
      stg_cmd_q    <= cmd_d;
      stg_len_q    <= (|len_d[15:11]) ? 11'h7FF : len_d[10:0];
      stg_rd_q     <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= data_byte_i;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  assign res_valid_o     = stg_valid_q;
  assign res_o.status    = stg_status_q;
  assign res_o.frame_cmd = stg_cmd_q;
  assign res_o.frame_len = stg_len_q;
  assign res_o.read_data = stg_rd_q ? mem_rdata_q : 8'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/crx_outq.sv =====
// two-entry result queue that decouples the output channel from the pipeline
`default_nettype none

module crx_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire crx_pkg::res_t res_i,
  output logic               in_ready_o,
  crx_out_if.source          out_o
);

  crx_pkg::res_t entry_q [2];
  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    occ;
  logic          pop;
  crx_pkg::res_t head;

  assign pop  = out_o.valid && out_o.ready;
  assign occ  = count_q + {1'b0, res_valid_i};
  // the result stage always drains into the queue, so count it as taken
  assign in_ready_o = (occ < 2'd2) || ((occ == 2'd2) && pop);
  assign count_d    = count_q + {1'b0, res_valid_i} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (res_valid_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

  assign head            = entry_q[rd_ptr_q];
  assign out_o.valid     = count_q != 2'd0;
  assign out_o.status    = head.status;
  assign out_o.frame_cmd = head.frame_cmd;
  assign out_o.frame_len = head.frame_len;
  assign out_o.read_data = head.read_data;

endmodule

`default_nettype wire

// ===== hw/rtl/checksummed_frame_receiver_top.sv =====
// Checksummed frame receiver top level.
// Requests arrive on the in_i channel: a received byte, an idle tick or a
// read of a stored payload byte. Frames are header, command, 16-bit
// little-endian length, payload, additive checksum, tail. Payload bytes go
// into an on-chip buffer of BUF_DEPTH bytes, read back by read requests.
// Every request transaction gives exactly one result transaction on out_o
// with a status, the current command byte, the saturated length and the
// read data.
// Throughput is one transaction per cycle while in_i.ready is high; each
// request needs one buffer access and one checksum add in a single pass.
// A result passes through the result stage, which holds the registered
// buffer read, and then the result queue before it can leave on out_o.
// When out_o stalls, requests are still taken until the result stage and
// the two-entry result queue together hold two results, then in_i.ready
// drops; it rises again in the cycle that out_o takes a result.
// The header byte, tail byte and idle limit sit in APB registers at byte
// addresses 0, 4 and 8. Reset returns them to 0xAA, 0x55 and 1000 and puts
// the receiver back to waiting for a header; the buffer is not cleared.
`default_nettype none

module checksummed_frame_receiver_top #(
  parameter int unsigned BUF_DEPTH = crx_pkg::BufDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  crx_in_if.sink           in_i,
  crx_out_if.source        out_o
);

  crx_pkg::cfg_t cfg;
  crx_pkg::res_t res;
  logic          res_valid;
  logic          in_ready;
  logic          accept;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  crx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crx_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .req_type_i   (in_i.req_type),
    .data_byte_i  (in_i.data_byte),
    .read_index_i (in_i.read_index),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  crx_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .in_ready_o  (in_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/checksummed_frame_receiver_top_tb.sv =====
// self-checking testbench for the checksummed frame receiver top level
`default_nettype none

module checksummed_frame_receiver_top_tb;
  import crx_pkg::*;

  localparam int unsigned Depth      = BufDepth;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  localparam logic [1:0] ReqReserved = 2'd3;

  localparam int RegHeader = 0;
  localparam int RegTail   = 1;
  localparam int RegIdle   = 2;

  typedef enum logic [2:0] {
    PhHeader, PhCmd, PhLenLo, PhLenHi, PhPayload, PhSum, PhTail
  } rx_phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [9:0] read_index;
  } req_item_t;

  logic clk_i;
  logic rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crx_in_if  in_vif ();
  crx_out_if out_vif ();

  checksummed_frame_receiver_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_vif),
    .out_o   (out_vif)
  );

  // shadow of the receiver
  cfg_t        rx_cfg;
  rx_phase_e   rx_phase;
  logic [7:0]  rx_cmd;
  logic [7:0]  rx_len_lo;
  logic [15:0] rx_len;
  logic [10:0] rx_pos;
  logic [7:0]  rx_sum;
  logic [15:0] rx_idle;
  logic [7:0]  rx_store [Depth];

  req_item_t request_backlog [$];
  res_t      predicted_results [$];

  req_item_t   drive_item;
  res_t        seen_res;
  res_t        want_res;
  logic        req_fire;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  int          hold_kick;
  int          hold_seen;
  bit          calm;
  int unsigned items_made;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  always #10 clk_i = ~clk_i;

  function automatic res_t predict_result(input req_item_t it);
    res_t r;
    r.status    = StNone;
    r.read_data = '0;
    case (it.req_type)
      ReqByte: begin
        rx_idle = '0;
        case (rx_phase)
          PhCmd: begin
            rx_cmd   = it.data_byte;
            rx_sum   = it.data_byte;
            rx_phase = PhLenLo;
          end
          PhLenLo: begin
            rx_len_lo = it.data_byte;
            rx_sum    = rx_sum + it.data_byte;
            rx_phase  = PhLenHi;
          end
          PhLenHi: begin
            rx_len = {it.data_byte, rx_len_lo};
            rx_sum = rx_sum + it.data_byte;
            rx_pos = '0;
            if (rx_len > Depth) begin
              r.status = StLenDrop;
              rx_phase = PhHeader;
            end else begin
              rx_phase = (rx_len != 16'd0) ? PhPayload : PhSum;
            end
          end
          PhPayload: begin
            if (rx_pos < Depth) begin
              rx_store[rx_pos] = it.data_byte;
              rx_pos = rx_pos + 11'd1;
            end
            rx_sum = rx_sum + it.data_byte;
            if (rx_pos >= rx_len) rx_phase = PhSum;
          end
          PhSum: begin
            if (it.data_byte == rx_sum) begin
              rx_phase = PhTail;
            end else begin
              r.status = StSumBad;
              rx_phase = PhHeader;
            end
          end
          PhTail: begin
            r.status = (it.data_byte == rx_cfg.tail_value) ? StAccept : StTailBad;
            rx_phase = PhHeader;
          end
          default: begin
            rx_phase = (it.data_byte == rx_cfg.header_value) ? PhCmd : PhHeader;
          end
        endcase
      end
      ReqIdle: begin
        if (rx_phase != PhHeader) begin
          if (rx_idle != 16'hFFFF) rx_idle = rx_idle + 16'd1;
          if (rx_idle > rx_cfg.idle_limit) begin
            rx_phase = PhHeader;
            rx_idle  = '0;
            r.status = StIdleReset;
          end
        end
      end
      ReqRead: begin
        if (it.read_index < Depth) r.read_data = rx_store[it.read_index];
      end
      default: ;
    endcase
    r.frame_cmd = rx_cmd;
    r.frame_len = (rx_len > 16'd2047) ? 11'd2047 : rx_len[10:0];
    return r;
  endfunction

  task automatic push_item(input logic [1:0] req, input logic [7:0] data,
                           input logic [9:0] idx);
    req_item_t it;
    it.req_type   = req;
    it.data_byte  = data;
    it.read_index = idx;
    request_backlog.push_back(it);
    if (req != ReqReserved) items_made++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(ReqByte, b, 10'($urandom));
  endtask

  // header, then the body with a run of idle ticks dropped in somewhere after the header
  task automatic push_frame(input logic [7:0] cmd, input int unsigned len, input bit bad_sum,
                            input bit bad_tail, input int unsigned idles);
    logic [7:0]  body [$];
    logic [7:0]  csum;
    int unsigned idle_at;
    body.push_back(cmd);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    csum = cmd + len[7:0] + len[15:8];
    if (len <= Depth) begin
      repeat (len) begin
        body.push_back(8'($urandom));
        csum = csum + body[$];
      end
      body.push_back(bad_sum ? (csum ^ 8'($urandom_range(1, 255))) : csum);
      if (!bad_sum) begin
        body.push_back(bad_tail ? (rx_cfg.tail_value ^ 8'($urandom_range(1, 255)))
                                : rx_cfg.tail_value);
      end
    end
    idle_at = $urandom_range(0, body.size() - 1);
    push_byte(rx_cfg.header_value);
    foreach (body[k]) begin
      if (k == idle_at) repeat (idles) push_item(ReqIdle, 8'($urandom), 10'($urandom));
      push_byte(body[k]);
    end
  endtask

  task automatic push_random_group();
    int unsigned sel;
    int unsigned len;
    int unsigned err;
    int unsigned idles;
    sel = $urandom_range(0, 99);
    len = $urandom_range(0, 99);
    if (len == 0) len = $urandom_range(Depth - 8, Depth);
    else if (len < 5) len = $urandom_range(25, 200);
    else len = $urandom_range(0, 24);
    if (sel < 65) begin
      err = $urandom_range(0, 19);
      if (err == 2) len = $urandom_range(Depth + 1, 65535);
      idles = 0;
      if (sel >= 55) begin
        idles = (rx_cfg.idle_limit <= 16) ? $urandom_range(0, rx_cfg.idle_limit + 2)
                                          : $urandom_range(0, 3);
      end
      push_frame(8'($urandom), len, err == 0, err == 1, idles);
    end else if (sel < 80) begin
      repeat ($urandom_range(1, 4)) push_item(ReqRead, 8'($urandom), 10'($urandom));
    end else if (sel < 88) begin
      repeat ($urandom_range(1, 3)) push_item(ReqIdle, 8'($urandom), 10'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) push_item(2'($urandom), 8'($urandom), 10'($urandom));
    end
  endtask

  // write a register, then read it back
  task automatic write_reg(input int idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == RegIdle) ? 32'h0000_FFFF : 32'h0000_00FF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (val & mask)) begin
      $display("%0t: register %0d read back expected %h actual %h", $time, idx,
               val & mask, prdata & mask);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegHeader: rx_cfg.header_value = val[7:0];
      RegTail:   rx_cfg.tail_value   = val[7:0];
      default:   rx_cfg.idle_limit   = val[15:0];
    endcase
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] tl,
                            input logic [15:0] lim);
    write_reg(RegHeader, {24'($urandom), hdr});
    write_reg(RegTail, {24'($urandom), tl});
    write_reg(RegIdle, {16'($urandom), lim});
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || in_vif.valid || predicted_results.size() != 0);
  endtask

  task automatic run_random(input int unsigned target);
    items_made = 0;
    while (items_made < target) push_random_group();
  endtask

  // request side
  always @(negedge clk_i) begin
    if (rst_ni && (!in_vif.valid || req_fire)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_vif.valid <= 1'b0;
      end else if (!calm && request_backlog.size() != 0 && $urandom_range(0, 11) == 0) begin
        src_gap <= $urandom_range(0, 7);
        in_vif.valid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        drive_item = request_backlog.pop_front();
        in_vif.req_type   <= drive_item.req_type;
        in_vif.data_byte  <= drive_item.data_byte;
        in_vif.read_index <= drive_item.read_index;
        in_vif.valid      <= 1'b1;
      end else begin
        in_vif.valid <= 1'b0;
      end
    end
  end

  // result side, with bursts of back-pressure and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_seen != hold_kick) begin
        hold_seen <= hold_kick;
        hold_left <= HoldCycles;
        out_vif.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_vif.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_vif.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 7);
        out_vif.ready <= 1'b0;
      end else begin
        out_vif.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= in_vif.valid && in_vif.ready;
      if (in_vif.valid && in_vif.ready) begin
        predicted_results.push_back(predict_result({in_vif.req_type, in_vif.data_byte,
                                                    in_vif.read_index}));
      end
      if (out_vif.valid && out_vif.ready) begin
        seen_res = {out_vif.status, out_vif.frame_cmd, out_vif.frame_len, out_vif.read_data};
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h/%h/%h/%h", $time,
                   seen_res.status, seen_res.frame_cmd, seen_res.frame_len,
                   seen_res.read_data);
          mismatch_count++;
        end else begin
          want_res = predicted_results.pop_front();
          if (seen_res !== want_res) begin
            $display("%0t: result mismatch expected st %h cmd %h len %h rd %h", $time,
                     want_res.status, want_res.frame_cmd, want_res.frame_len,
                     want_res.read_data);
            $display("%0t:                 actual   st %h cmd %h len %h rd %h", $time,
                     seen_res.status, seen_res.frame_cmd, seen_res.frame_len,
                     seen_res.read_data);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_vif.valid      = 1'b0;
    in_vif.req_type   = ReqIdle;
    in_vif.data_byte  = '0;
    in_vif.read_index = '0;
    out_vif.ready     = 1'b0;
    req_fire          = 1'b0;
    src_gap           = 0;
    sink_gap          = 0;
    hold_left         = 0;
    hold_kick         = 0;
    hold_seen         = 0;
    calm              = 1'b0;
    items_made        = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    rx_cfg.header_value = HeaderReset;
    rx_cfg.tail_value   = TailReset;
    rx_cfg.idle_limit   = IdleReset;
    rx_phase  = PhHeader;
    rx_cmd    = '0;
    rx_len_lo = '0;
    rx_len    = '0;
    rx_pos    = '0;
    rx_sum    = '0;
    rx_idle   = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // a full-depth frame first so that every buffer entry holds a known byte
    push_frame(8'($urandom), Depth, 1'b0, 1'b0, 0);
    push_item(ReqIdle, 8'($urandom), 10'($urandom));
    push_frame(8'hFF, 0, 1'b0, 1'b0, 0);
    push_frame(8'h00, 0, 1'b0, 1'b1, 0);
    push_frame(8'h5A, 0, 1'b1, 1'b0, 0);
    push_frame(8'h81, 65535, 1'b0, 1'b0, 0);
    push_frame(8'h7E, Depth + 1, 1'b0, 1'b0, 0);
    push_frame(8'h3C, 0, 1'b0, 1'b0, 1);
    push_item(ReqReserved, 8'hFF, 10'h3FF);
    push_item(ReqRead, 8'h00, 10'd0);
    push_item(ReqRead, 8'hFF, 10'h3FF);
    wait_drained();

    set_config(8'h00, 8'hFF, 16'd1);
    run_random(100);
    wait_drained();

    set_config(8'hFF, 8'h00, 16'hFFFF);
    run_random(100);
    wait_drained();

    // the result side holds off while requests keep coming
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
    run_random(100);
    hold_kick++;
    wait_drained();

    repeat (2) begin
      set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
      run_random(100);
      wait_drained();
    end

    calm = 1'b1;
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
    run_random(100);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/crx_pkg.sv
hw/rtl/crx_if.sv
hw/rtl/crx_cfg.sv
hw/rtl/crx_ctrl.sv
hw/rtl/crx_outq.sv
hw/rtl/checksummed_frame_receiver_top.sv
tb/checksummed_frame_receiver_top_tb.sv
